### rtl/dead_reckoning_pose_tracker_unit_assert.svh
// Assertion macros shared by the pose tracker RTL.
`ifndef DEAD_RECKONING_POSE_TRACKER_UNIT_ASSERT_SVH
`define DEAD_RECKONING_POSE_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define DRPT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DRPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/drpt_pkg.sv
// Types, constants and table builder for the dead-reckoning pose tracker.
package drpt_pkg;

   localparam int SINE_TABLE_ENTRIES = 1440;
   localparam int POSITION_FRAC_BITS = 4;

   localparam int POS_W   = 18;
   localparam int FIELD_W = 17;
   localparam int HEAD_W  = 13;
   localparam int AMT_W   = 15;
   localparam int MODE_W  = 2;
   localparam int AREA_W  = 2;
   localparam int QUAD_W  = 2;
   localparam int Q15_W   = 15;
   localparam int TRIG_W  = Q15_W + 1;
   localparam int PROD_W  = AMT_W + TRIG_W;
   localparam int WIDE_W  = POS_W + 1;
   localparam int ROT_W   = 17;

   localparam int HEAD_QUARTER_N = 1440;
   localparam int HEAD_FULL_N    = 4 * HEAD_QUARTER_N;
   localparam int ROM_DEPTH      = HEAD_QUARTER_N + 1;
   localparam int ROM_AW         = $clog2(ROM_DEPTH);

   localparam logic [HEAD_W-1:0] HEAD_ZERO    = '0;
   localparam logic [HEAD_W-1:0] HEAD_QUARTER = HEAD_W'(HEAD_QUARTER_N);
   localparam logic [HEAD_W-1:0] HEAD_HALF    = HEAD_W'(2 * HEAD_QUARTER_N);
   localparam logic [HEAD_W-1:0] HEAD_3Q      = HEAD_W'(3 * HEAD_QUARTER_N);
   localparam logic [HEAD_W-1:0] HEAD_FULL    = HEAD_W'(HEAD_FULL_N);
   localparam logic [HEAD_W-1:0] HEAD_45      = HEAD_W'(720);
   localparam logic [HEAD_W-1:0] HEAD_135     = HEAD_W'(2160);
   localparam logic [HEAD_W-1:0] HEAD_225     = HEAD_W'(3600);
   localparam logic [HEAD_W-1:0] HEAD_315     = HEAD_W'(5040);

   localparam int FIELD_DEFAULT_CM = 400;
   localparam logic [FIELD_W-1:0] FIELD_RESET =
      FIELD_W'(FIELD_DEFAULT_CM << POSITION_FRAC_BITS);

   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
   localparam int          Q15_MAX     = 32767;

   // request modes
   localparam logic [MODE_W-1:0] MODE_LOAD     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ROTATE   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CORRECT  = 2'd3;

   // field areas
   localparam logic [AREA_W-1:0] AREA_A = 2'd0;
   localparam logic [AREA_W-1:0] AREA_B = 2'd1;
   localparam logic [AREA_W-1:0] AREA_C = 2'd2;
   localparam logic [AREA_W-1:0] AREA_D = 2'd3;

   // heading quadrants
   localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
   localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
   localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;
   localparam logic [QUAD_W-1:0] QUAD_3 = 2'd3;

   // register map
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam logic [CSR_IDX_W-1:0] REG_START_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_HEADING = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIELD_X_SIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FIELD_Y_SIZE  = 3'd4;

   typedef struct packed {
      logic [POS_W-1:0]   start_x;
      logic [POS_W-1:0]   start_y;
      logic [HEAD_W-1:0]  start_heading;
      logic [FIELD_W-1:0] field_x_size;
      logic [FIELD_W-1:0] field_y_size;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [HEAD_W-1:0] heading;
   } pose_type;

   // sin_mag = table at remainder, cos_mag = table at quarter minus remainder
   typedef struct packed {
      logic [QUAD_W-1:0] quad;
      logic [Q15_W-1:0]  sin_mag;
      logic [Q15_W-1:0]  cos_mag;
   } trig_type;

   typedef logic [Q15_W-1:0] sine_tab_type [0:ROM_DEPTH-1];

   function automatic logic [QUAD_W-1:0] quadrant_of(input logic [HEAD_W-1:0] h);
      logic [QUAD_W-1:0] q;
      if (h >= HEAD_3Q)           q = QUAD_3;
      else if (h >= HEAD_HALF)    q = QUAD_2;
      else if (h >= HEAD_QUARTER) q = QUAD_1;
      else                        q = QUAD_0;
      return q;
   endfunction

   function automatic logic [ROM_AW-1:0] heading_rem(input logic [HEAD_W-1:0] h);
      logic [HEAD_W-1:0] base;
      case (quadrant_of(h))
         QUAD_3:  base = HEAD_3Q;
         QUAD_2:  base = HEAD_HALF;
         QUAD_1:  base = HEAD_QUARTER;
         default: base = HEAD_ZERO;
      endcase
      return ROM_AW'(h - base);
   endfunction

   // Taylor term divisors (2k)(2k+1)
   function automatic logic [63:0] taylor_div(input int k, input logic [63:0] v);
      logic [63:0] q;
      case (k)
         1:       q = v / 64'd6;
         2:       q = v / 64'd20;
         3:       q = v / 64'd42;
         4:       q = v / 64'd72;
         5:       q = v / 64'd110;
         6:       q = v / 64'd156;
         default: q = v / 64'd210;
      endcase
      return q;
   endfunction

   // sin(90 deg * i / N) in unsigned Q0.15, Taylor series evaluated in Q30
   function automatic logic [Q15_W-1:0] sine_q15(input int i);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        mag;
      logic signed [63:0] sum;
      logic signed [63:0] r;
      int                 k;
      x   = (PI_HALF_Q30 * 64'(i)) / 64'(SINE_TABLE_ENTRIES);
      x2  = (x * x) >> 30;
      sum = $signed(x);
      mag = x;
      for (k = 1; k <= 7; k++) begin
         mag = taylor_div(k, (mag * x2) >> 30);
         if (k % 2 == 1) sum = sum - $signed(mag);
         else            sum = sum + $signed(mag);
      end
      if (sum < 0) sum = 0;
      r = (sum + 64'sd16384) >>> 15;
      if (r > Q15_MAX) r = Q15_MAX;
      return Q15_W'(r);
   endfunction

   // indexed by heading remainder, so no run-time scaling by N is needed
   function automatic sine_tab_type build_sine_table();
      sine_tab_type t;
      int           j;
      for (j = 0; j < ROM_DEPTH; j++)
         t[j] = sine_q15((j * SINE_TABLE_ENTRIES) / HEAD_QUARTER_N);
      return t;
   endfunction

endpackage

### rtl/drpt_csr.sv
// Register file for start pose and field size, APB-style access.
module drpt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [drpt_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [drpt_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [drpt_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                            csr_pready,
   output drpt_pkg::cfg_type               cfg
);

   drpt_pkg::cfg_type                  cfg_ff;
   drpt_pkg::cfg_type                  cfg_in;
   logic [drpt_pkg::CSR_IDX_W-1:0]     reg_idx;
   logic                               wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[drpt_pkg::CSR_AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            drpt_pkg::REG_START_X:
               cfg_in.start_x = csr_pwdata[drpt_pkg::POS_W-1:0];
            drpt_pkg::REG_START_Y:
               cfg_in.start_y = csr_pwdata[drpt_pkg::POS_W-1:0];
            drpt_pkg::REG_START_HEADING:
               cfg_in.start_heading = csr_pwdata[drpt_pkg::HEAD_W-1:0];
            drpt_pkg::REG_FIELD_X_SIZE:
               cfg_in.field_x_size = csr_pwdata[drpt_pkg::FIELD_W-1:0];
            drpt_pkg::REG_FIELD_Y_SIZE:
               cfg_in.field_y_size = csr_pwdata[drpt_pkg::FIELD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_x       <= '0;
         cfg_ff.start_y       <= '0;
         cfg_ff.start_heading <= '0;
         cfg_ff.field_x_size  <= drpt_pkg::FIELD_RESET;
         cfg_ff.field_y_size  <= drpt_pkg::FIELD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // signed registers read back sign-extended
   always_comb begin
      unique case (reg_idx)
         drpt_pkg::REG_START_X:
            csr_prdata = drpt_pkg::CSR_DW'($signed(cfg_ff.start_x));
         drpt_pkg::REG_START_Y:
            csr_prdata = drpt_pkg::CSR_DW'($signed(cfg_ff.start_y));
         drpt_pkg::REG_START_HEADING:
            csr_prdata = drpt_pkg::CSR_DW'(cfg_ff.start_heading);
         drpt_pkg::REG_FIELD_X_SIZE:
            csr_prdata = drpt_pkg::CSR_DW'(cfg_ff.field_x_size);
         drpt_pkg::REG_FIELD_Y_SIZE:
            csr_prdata = drpt_pkg::CSR_DW'(cfg_ff.field_y_size);
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/drpt_sine_rom.sv
// Quarter-wave sine table, two read ports, registered read data.
module drpt_sine_rom (
   input  logic                          clock,
   input  logic [drpt_pkg::ROM_AW-1:0]   addr_a,
   input  logic [drpt_pkg::ROM_AW-1:0]   addr_b,
   output logic [drpt_pkg::Q15_W-1:0]    data_a,
   output logic [drpt_pkg::Q15_W-1:0]    data_b
);

   localparam drpt_pkg::sine_tab_type SINE_ROM = drpt_pkg::build_sine_table();

   logic [drpt_pkg::Q15_W-1:0] data_a_ff;
   logic [drpt_pkg::Q15_W-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      data_a_ff <= SINE_ROM[addr_a];
      data_b_ff <= SINE_ROM[addr_b];
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

### rtl/drpt_pose_step.sv
// Next-pose logic: load, straight move, rotate, wall correction, area.
module drpt_pose_step (
   input  logic [drpt_pkg::MODE_W-1:0]         mode,
   input  logic signed [drpt_pkg::AMT_W-1:0]   amount,
   input  drpt_pkg::pose_type                  pose,
   input  drpt_pkg::cfg_type                   cfg,
   input  drpt_pkg::trig_type                  trig,
   output drpt_pkg::pose_type                  pose_next,
   output logic [drpt_pkg::AREA_W-1:0]         area,
   output logic                                saturated
);

   localparam int POS_W  = drpt_pkg::POS_W;
   localparam int WIDE_W = drpt_pkg::WIDE_W;
   localparam int PROD_W = drpt_pkg::PROD_W;
   localparam int ROT_W  = drpt_pkg::ROT_W;
   localparam logic [ROT_W-1:0] ROT_OFFSET = ROT_W'(3 * drpt_pkg::HEAD_FULL_N);

   logic signed [drpt_pkg::TRIG_W-1:0]  sin_val;
   logic signed [drpt_pkg::TRIG_W-1:0]  cos_val;
   logic signed [drpt_pkg::TRIG_W-1:0]  sin_pos;
   logic signed [drpt_pkg::TRIG_W-1:0]  cos_pos;
   logic signed [PROD_W-1:0]            prod_x;
   logic signed [PROD_W-1:0]            prod_y;
   logic signed [PROD_W-1:0]            rnd_x;
   logic signed [PROD_W-1:0]            rnd_y;
   logic signed [WIDE_W-1:0]            move_x;
   logic signed [WIDE_W-1:0]            move_y;
   logic signed [WIDE_W-1:0]            far_x;
   logic signed [WIDE_W-1:0]            far_y;
   logic [ROT_W-1:0]                    rot_sum;
   logic [ROT_W-1:0]                    rot_wrap;
   logic [drpt_pkg::HEAD_W-1:0]         load_heading;
   logic [drpt_pkg::FIELD_W-2:0]        half_x;
   logic [drpt_pkg::FIELD_W-2:0]        half_y;
   logic                                above_x;
   logic                                above_y;

   function automatic logic clip_hit(input logic [WIDE_W-1:0] v);
      return v[WIDE_W-1] != v[WIDE_W-2];
   endfunction

   function automatic logic [POS_W-1:0] clip_pos(input logic [WIDE_W-1:0] v);
      logic [POS_W-1:0] r;
      if (clip_hit(v)) r = v[WIDE_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      else             r = v[POS_W-1:0];
      return r;
   endfunction

   // signs from the heading quadrant
   assign sin_pos = $signed({1'b0, trig.sin_mag});
   assign cos_pos = $signed({1'b0, trig.cos_mag});

   always_comb begin
      case (trig.quad)
         drpt_pkg::QUAD_0: begin sin_val = sin_pos;  cos_val = cos_pos;  end
         drpt_pkg::QUAD_1: begin sin_val = cos_pos;  cos_val = -sin_pos; end
         drpt_pkg::QUAD_2: begin sin_val = -sin_pos; cos_val = -cos_pos; end
         default:          begin sin_val = -cos_pos; cos_val = sin_pos;  end
      endcase
   end

   // Q15 product, round half up
   assign prod_x = PROD_W'(amount) * PROD_W'(cos_val);
   assign prod_y = PROD_W'(amount) * PROD_W'(sin_val);
   assign rnd_x  = prod_x + PROD_W'(16384);
   assign rnd_y  = prod_y + PROD_W'(16384);
   assign move_x = WIDE_W'($signed(pose.x)) + WIDE_W'($signed(rnd_x[PROD_W-1:15]));
   assign move_y = WIDE_W'($signed(pose.y)) + WIDE_W'($signed(rnd_y[PROD_W-1:15]));

   // biased by three turns so the sum is never negative, then folded back
   assign rot_sum = ROT_W'(pose.heading) + ROT_W'(amount) + ROT_OFFSET;

   always_comb begin
      rot_wrap = rot_sum;
      for (int k = 1; k <= 6; k++) begin
         if (rot_sum >= ROT_W'(k * drpt_pkg::HEAD_FULL_N))
            rot_wrap = rot_sum - ROT_W'(k * drpt_pkg::HEAD_FULL_N);
      end
   end

   assign load_heading = (cfg.start_heading >= drpt_pkg::HEAD_FULL) ?
                         cfg.start_heading - drpt_pkg::HEAD_FULL : cfg.start_heading;

   assign far_x = $signed({2'b00, cfg.field_x_size}) - WIDE_W'(amount);
   assign far_y = $signed({2'b00, cfg.field_y_size}) - WIDE_W'(amount);

   always_comb begin
      pose_next = pose;
      saturated = 1'b0;
      unique case (mode)
         drpt_pkg::MODE_LOAD: begin
            pose_next.x       = cfg.start_x;
            pose_next.y       = cfg.start_y;
            pose_next.heading = load_heading;
         end
         drpt_pkg::MODE_STRAIGHT: begin
            pose_next.x = clip_pos(move_x);
            pose_next.y = clip_pos(move_y);
            saturated   = clip_hit(move_x) || clip_hit(move_y);
         end
         drpt_pkg::MODE_ROTATE: begin
            pose_next.heading = rot_wrap[drpt_pkg::HEAD_W-1:0];
         end
         default: begin
            // snap to the nearest wall direction, bounds on the diagonals
            if (pose.heading >= drpt_pkg::HEAD_315 || pose.heading < drpt_pkg::HEAD_45) begin
               pose_next.x       = clip_pos(far_x);
               pose_next.heading = drpt_pkg::HEAD_ZERO;
            end else if (pose.heading < drpt_pkg::HEAD_135) begin
               pose_next.y       = clip_pos(far_y);
               pose_next.heading = drpt_pkg::HEAD_QUARTER;
            end else if (pose.heading < drpt_pkg::HEAD_225) begin
               pose_next.x       = POS_W'(amount);
               pose_next.heading = drpt_pkg::HEAD_HALF;
            end else begin
               pose_next.y       = POS_W'(amount);
               pose_next.heading = drpt_pkg::HEAD_3Q;
            end
         end
      endcase
   end

   assign half_x  = cfg.field_x_size[drpt_pkg::FIELD_W-1:1];
   assign half_y  = cfg.field_y_size[drpt_pkg::FIELD_W-1:1];
   assign above_x = $signed({pose_next.x[POS_W-1], pose_next.x}) > $signed({3'b000, half_x});
   assign above_y = $signed({pose_next.y[POS_W-1], pose_next.y}) > $signed({3'b000, half_y});

   always_comb begin
      case ({above_y, above_x})
         2'b00:   area = drpt_pkg::AREA_A;
         2'b01:   area = drpt_pkg::AREA_B;
         2'b11:   area = drpt_pkg::AREA_C;
         default: area = drpt_pkg::AREA_D;
      endcase
   end

endmodule

### rtl/dead_reckoning_pose_tracker_unit.sv
// Top level of the dead-reckoning pose tracker.
// The tracker keeps x, y (18-bit signed, 1/16 cm) and heading (0..5759, 1/16 degree) and
// answers every request with one response carrying the updated pose, the field area and
// a saturation flag for straight moves. It takes one request per clock while the response
// side is not stalled; an accepted request passes through the request register and then the
// response register. Sine and cosine come from a 1441-entry quarter-wave ROM with a
// registered read that is addressed by the heading being written, so its data always
// matches the current heading and back-to-back requests need no wait. No clearing
// pass is needed after reset. Configuration registers should only be written when no
// request is in flight.
`include "dead_reckoning_pose_tracker_unit_assert.svh"

module dead_reckoning_pose_tracker_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [drpt_pkg::MODE_W-1:0]            req_mode,
   input  logic signed [drpt_pkg::AMT_W-1:0]      req_amount,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [drpt_pkg::POS_W-1:0]      rsp_pos_x,
   output logic signed [drpt_pkg::POS_W-1:0]      rsp_pos_y,
   output logic [drpt_pkg::HEAD_W-1:0]            rsp_heading,
   output logic [drpt_pkg::AREA_W-1:0]            rsp_area,
   output logic                                   rsp_saturated,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [drpt_pkg::CSR_AW-1:0]            csr_paddr,
   input  logic [drpt_pkg::CSR_DW-1:0]            csr_pwdata,
   output logic [drpt_pkg::CSR_DW-1:0]            csr_prdata,
   output logic                                   csr_pready
);

   drpt_pkg::cfg_type                     cfg;

   // request register
   logic                                  in_valid_ff;
   logic                                  in_valid_in;
   logic [drpt_pkg::MODE_W-1:0]           in_mode_ff;
   logic signed [drpt_pkg::AMT_W-1:0]     in_amount_ff;
   logic                                  req_take;

   // pose state
   drpt_pkg::pose_type                    pose_ff;
   drpt_pkg::pose_type                    pose_in;
   drpt_pkg::pose_type                    pose_next;
   logic [drpt_pkg::AREA_W-1:0]           step_area;
   logic                                  step_sat;

   // trig lookup
   logic [drpt_pkg::HEAD_W-1:0]           look_heading;
   logic [drpt_pkg::ROM_AW-1:0]           look_rem;
   logic [drpt_pkg::QUAD_W-1:0]           trig_quad_ff;
   drpt_pkg::trig_type                    trig;

   // response register
   logic                                  rsp_advance;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic signed [drpt_pkg::POS_W-1:0]     rsp_pos_x_ff;
   logic signed [drpt_pkg::POS_W-1:0]     rsp_pos_y_ff;
   logic [drpt_pkg::HEAD_W-1:0]           rsp_heading_ff;
   logic [drpt_pkg::AREA_W-1:0]           rsp_area_ff;
   logic                                  rsp_saturated_ff;

   drpt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign rsp_advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || rsp_advance;
   assign req_take    = req_valid && req_ready;

   always_comb begin
      if (req_take)         in_valid_in = 1'b1;
      else if (rsp_advance) in_valid_in = 1'b0;
      else                  in_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff   <= req_mode;
         in_amount_ff <= req_amount;
      end
   end

   drpt_pose_step u_step (
      .mode      (in_mode_ff),
      .amount    (in_amount_ff),
      .pose      (pose_ff),
      .cfg       (cfg),
      .trig      (trig),
      .pose_next (pose_next),
      .area      (step_area),
      .saturated (step_sat)
   );

   assign pose_in = rsp_advance ? pose_next : pose_ff;

   always_ff @(posedge clock) begin
      if (reset) pose_ff <= '0;
      else       pose_ff <= pose_in;
   end

   // look up the heading that is about to be stored; held at zero in reset
   assign look_heading = reset ? drpt_pkg::HEAD_ZERO : pose_in.heading;
   assign look_rem     = drpt_pkg::heading_rem(look_heading);

   drpt_sine_rom u_rom (
      .clock  (clock),
      .addr_a (look_rem),
      .addr_b (drpt_pkg::ROM_AW'(drpt_pkg::HEAD_QUARTER_N) - look_rem),
      .data_a (trig.sin_mag),
      .data_b (trig.cos_mag)
   );

   always_ff @(posedge clock) begin
      trig_quad_ff <= drpt_pkg::quadrant_of(look_heading);
   end

   assign trig.quad = trig_quad_ff;

   always_comb begin
      if (rsp_advance)    rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_advance) begin
         rsp_pos_x_ff     <= $signed(pose_next.x);
         rsp_pos_y_ff     <= $signed(pose_next.y);
         rsp_heading_ff   <= pose_next.heading;
         rsp_area_ff      <= step_area;
         rsp_saturated_ff <= step_sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = rsp_pos_x_ff;
   assign rsp_pos_y     = rsp_pos_y_ff;
   assign rsp_heading   = rsp_heading_ff;
   assign rsp_area      = rsp_area_ff;
   assign rsp_saturated = rsp_saturated_ff;

   `DRPT_ASSERT_NOW(a_heading_range, 1'b1, pose_ff.heading < drpt_pkg::HEAD_FULL, "heading out of range")
   `DRPT_ASSERT_NOW(a_trig_aligned, 1'b1, trig_quad_ff == drpt_pkg::quadrant_of(pose_ff.heading), "trig lookup not aligned with heading")
   `DRPT_ASSERT_NEXT(a_rsp_matches_state, rsp_advance, rsp_heading == pose_ff.heading, "response heading differs from state")
   `DRPT_ASSERT_NEXT(a_sat_straight_only, rsp_advance && in_mode_ff != drpt_pkg::MODE_STRAIGHT, !rsp_saturated, "saturation outside straight move")

endmodule

### tb/dead_reckoning_pose_tracker_unit_test.sv
// Self-checking testbench for the pose tracker: directed table, then random phases.
module dead_reckoning_pose_tracker_unit_test;
   import drpt_pkg::*;

   localparam longint POS_TOP    = 131071;
   localparam longint POS_BOTTOM = -131072;
   localparam int     PHASE_LEN  = 300;
   localparam int     PHASES     = 6;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [HEAD_W-1:0]       heading;
      logic [AREA_W-1:0]       area;
      logic                    sat;
   } pose_report_t;

   typedef struct {
      bit                      is_csr;
      logic [CSR_IDX_W-1:0]    csr_idx;
      logic [CSR_DW-1:0]       csr_data;
      logic [MODE_W-1:0]       mode;
      logic signed [AMT_W-1:0] amount;
      bit                      typed;
      pose_report_t            want;
   } plan_row_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [MODE_W-1:0]         req_mode = MODE_LOAD;
   logic signed [AMT_W-1:0]   req_amount = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [POS_W-1:0]   rsp_pos_x;
   logic signed [POS_W-1:0]   rsp_pos_y;
   logic [HEAD_W-1:0]         rsp_heading;
   logic [AREA_W-1:0]         rsp_area;
   logic                      rsp_saturated;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]         csr_paddr = '0;
   logic [CSR_DW-1:0]         csr_pwdata = '0;
   logic [CSR_DW-1:0]         csr_prdata;
   logic                      csr_pready;

   // tracker state and register copies
   logic signed [POS_W-1:0]   trk_x, trk_y;
   logic [HEAD_W-1:0]         trk_head;
   logic signed [POS_W-1:0]   cfg_start_x, cfg_start_y;
   logic [HEAD_W-1:0]         cfg_start_head;
   logic [FIELD_W-1:0]        cfg_field_x, cfg_field_y;
   logic [Q15_W-1:0]          sine_tab [0:SINE_TABLE_ENTRIES];

   pose_report_t              pending_poses [$];
   plan_row_t                 plan [$];
   int                        mismatches = 0;
   int                        stall_left = 0;
   bit                        gaps_on = 1'b1;

   dead_reckoning_pose_tracker_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_amount    (req_amount),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_heading   (rsp_heading),
      .rsp_area      (rsp_area),
      .rsp_saturated (rsp_saturated),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #5 clock = ~clock;

   // sin(90 deg * idx / N) in unsigned Q0.15: truncated Taylor terms in Q30, then rounded
   function automatic logic [Q15_W-1:0] quarter_wave_q15(input int idx);
      longint unsigned ang, ang2, term;
      longint          acc, rnd;
      int              k;
      ang  = (PI_HALF_Q30 * longint'(idx)) / longint'(SINE_TABLE_ENTRIES);
      ang2 = (ang * ang) >> 30;
      acc  = longint'(ang);
      term = ang;
      for (k = 1; k <= 7; k++) begin
         term = ((term * ang2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      rnd = (acc + 16384) >>> 15;
      if (rnd > Q15_MAX) rnd = Q15_MAX;
      return rnd[Q15_W-1:0];
   endfunction

   function automatic longint q15_round(input longint p);
      if (p >= 0) return (p + 16384) >>> 15;
      return -(((-p) + 16383) >>> 15);
   endfunction

   function automatic logic signed [POS_W-1:0] clamp_pos(input longint v, output bit hit);
      hit = 1'b0;
      if (v > POS_TOP) begin
         hit = 1'b1;
         return POS_TOP[POS_W-1:0];
      end
      if (v < POS_BOTTOM) begin
         hit = 1'b1;
         return POS_BOTTOM[POS_W-1:0];
      end
      return v[POS_W-1:0];
   endfunction

   function automatic void note_csr_write(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DW-1:0] d);
      case (idx)
         REG_START_X:       cfg_start_x    = d[POS_W-1:0];
         REG_START_Y:       cfg_start_y    = d[POS_W-1:0];
         REG_START_HEADING: cfg_start_head = d[HEAD_W-1:0];
         REG_FIELD_X_SIZE:  cfg_field_x    = d[FIELD_W-1:0];
         REG_FIELD_Y_SIZE:  cfg_field_y    = d[FIELD_W-1:0];
         default: ;
      endcase
   endfunction

   // one request against the tracker copy; returns the pose it should report
   function automatic pose_report_t advance_pose(input logic [MODE_W-1:0] mode,
                                                 input logic signed [AMT_W-1:0] amount);
      pose_report_t rep;
      longint       h, r, a, b, s, c, hx, hy;
      int           q;
      bit           hit_x, hit_y, ignored;
      hit_x = 1'b0;
      hit_y = 1'b0;
      case (mode)
         MODE_LOAD: begin
            trk_x = cfg_start_x;
            trk_y = cfg_start_y;
            h = longint'(cfg_start_head);
            if (h >= HEAD_FULL_N) h = h - HEAD_FULL_N;
            trk_head = h[HEAD_W-1:0];
         end
         MODE_STRAIGHT: begin
            q = int'(trk_head) / HEAD_QUARTER_N;
            r = longint'(trk_head) - longint'(q) * HEAD_QUARTER_N;
            a = sine_tab[(r * SINE_TABLE_ENTRIES) / HEAD_QUARTER_N];
            b = sine_tab[((HEAD_QUARTER_N - r) * SINE_TABLE_ENTRIES) / HEAD_QUARTER_N];
            case (q)
               0: begin s = a;  c = b;  end
               1: begin s = b;  c = -a; end
               2: begin s = -a; c = -b; end
               default: begin s = -b; c = a; end
            endcase
            trk_x = clamp_pos(longint'(trk_x) + q15_round(longint'(amount) * c), hit_x);
            trk_y = clamp_pos(longint'(trk_y) + q15_round(longint'(amount) * s), hit_y);
         end
         MODE_ROTATE: begin
            h = (longint'(trk_head) + longint'(amount)) % HEAD_FULL_N;
            if (h < 0) h = h + HEAD_FULL_N;
            trk_head = h[HEAD_W-1:0];
         end
         default: begin
            // snap to the nearest right angle, distance measured to the facing wall
            if (trk_head >= HEAD_315 || trk_head < HEAD_45) begin
               trk_x = clamp_pos(longint'(cfg_field_x) - longint'(amount), ignored);
               trk_head = HEAD_ZERO;
            end else if (trk_head < HEAD_135) begin
               trk_y = clamp_pos(longint'(cfg_field_y) - longint'(amount), ignored);
               trk_head = HEAD_QUARTER;
            end else if (trk_head < HEAD_225) begin
               trk_x = clamp_pos(longint'(amount), ignored);
               trk_head = HEAD_HALF;
            end else begin
               trk_y = clamp_pos(longint'(amount), ignored);
               trk_head = HEAD_3Q;
            end
         end
      endcase
      hx = longint'(cfg_field_x) >> 1;
      hy = longint'(cfg_field_y) >> 1;
      if (longint'(trk_x) <= hx) rep.area = (longint'(trk_y) <= hy) ? AREA_A : AREA_D;
      else rep.area = (longint'(trk_y) <= hy) ? AREA_B : AREA_C;
      rep.x       = trk_x;
      rep.y       = trk_y;
      rep.heading = trk_head;
      rep.sat     = hit_x | hit_y;
      return rep;
   endfunction

   function automatic void plan_req(input logic [MODE_W-1:0] mode,
                                    input logic signed [AMT_W-1:0] amount);
      plan_row_t row;
      row = '{default: '0};
      row.mode   = mode;
      row.amount = amount;
      plan.push_back(row);
   endfunction

   function automatic void plan_req_known(input logic [MODE_W-1:0] mode,
                                          input logic signed [AMT_W-1:0] amount,
                                          input longint x, input longint y,
                                          input int head, input logic [AREA_W-1:0] area);
      plan_row_t row;
      row = '{default: '0};
      row.mode         = mode;
      row.amount       = amount;
      row.typed        = 1'b1;
      row.want.x       = x[POS_W-1:0];
      row.want.y       = y[POS_W-1:0];
      row.want.heading = head[HEAD_W-1:0];
      row.want.area    = area;
      row.want.sat     = 1'b0;
      plan.push_back(row);
   endfunction

   function automatic void plan_csr(input logic [CSR_IDX_W-1:0] idx,
                                    input logic [CSR_DW-1:0] d);
      plan_row_t row;
      row = '{default: '0};
      row.is_csr   = 1'b1;
      row.csr_idx  = idx;
      row.csr_data = d;
      plan.push_back(row);
   endfunction

   task automatic issue_request(input logic [MODE_W-1:0] mode,
                                input logic signed [AMT_W-1:0] amount,
                                input bit typed, input pose_report_t want);
      pose_report_t predicted;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_amount <= amount;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_pose(mode, amount);
      pending_poses.push_back(typed ? want : predicted);
   endtask

   // drop valid and let every outstanding request drain before touching registers
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DW-1:0] d);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= d;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      note_csr_write(idx, d);
   endtask

   task automatic program_phase(input int ph);
      case (ph)
         0: begin
            csr_write(REG_START_X, 32'd0);
            csr_write(REG_START_Y, 32'd0);
            csr_write(REG_START_HEADING, 32'd0);
            csr_write(REG_FIELD_X_SIZE, 32'd6400);
            csr_write(REG_FIELD_Y_SIZE, 32'd6400);
         end
         1: begin
            csr_write(REG_START_X, 32'h0001_FFFF);
            csr_write(REG_START_Y, 32'h0002_0000);
            csr_write(REG_START_HEADING, 32'h0000_1FFF);
            csr_write(REG_FIELD_X_SIZE, 32'h0001_FFFF);
            csr_write(REG_FIELD_Y_SIZE, 32'd0);
         end
         2: begin
            csr_write(REG_START_X, 32'hFFFE_0000);
            csr_write(REG_START_Y, 32'h0001_FFFF);
            csr_write(REG_START_HEADING, 32'd5759);
            csr_write(REG_FIELD_X_SIZE, 32'd0);
            csr_write(REG_FIELD_Y_SIZE, 32'hFFFF_FFFF);
         end
         3: begin
            csr_write(REG_START_X, 32'd0);
            csr_write(REG_START_Y, 32'd0);
            csr_write(REG_START_HEADING, 32'd0);
            csr_write(REG_FIELD_X_SIZE, 32'd0);
            csr_write(REG_FIELD_Y_SIZE, 32'd0);
         end
         default: begin
            csr_write(REG_START_X, $urandom());
            csr_write(REG_START_Y, $urandom());
            csr_write(REG_START_HEADING, $urandom());
            csr_write(REG_FIELD_X_SIZE, $urandom());
            csr_write(REG_FIELD_Y_SIZE, $urandom());
         end
      endcase
      // addresses past the register map must be ignored
      csr_write(CSR_IDX_W'($urandom_range(5, 7)), $urandom());
   endtask

   // response side back-pressure in bursts of random length
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_poses
      pose_report_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_poses.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = pending_poses.pop_front();
            if (rsp_pos_x !== want.x) begin
               $error("pos_x: expected %0d, got %0d", want.x, rsp_pos_x);
               mismatches++;
            end
            if (rsp_pos_y !== want.y) begin
               $error("pos_y: expected %0d, got %0d", want.y, rsp_pos_y);
               mismatches++;
            end
            if (rsp_heading !== want.heading) begin
               $error("heading: expected %0d, got %0d", want.heading, rsp_heading);
               mismatches++;
            end
            if (rsp_area !== want.area) begin
               $error("area: expected %0d, got %0d", want.area, rsp_area);
               mismatches++;
            end
            if (rsp_saturated !== want.sat) begin
               $error("saturated: expected %0d, got %0d", want.sat, rsp_saturated);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int                      i, ph, n, pick;
      logic [MODE_W-1:0]       mode;
      logic signed [AMT_W-1:0] amount;

      for (i = 0; i <= SINE_TABLE_ENTRIES; i++) sine_tab[i] = quarter_wave_q15(i);
      trk_x          = '0;
      trk_y          = '0;
      trk_head       = HEAD_ZERO;
      cfg_start_x    = '0;
      cfg_start_y    = '0;
      cfg_start_head = HEAD_ZERO;
      cfg_field_x    = FIELD_RESET;
      cfg_field_y    = FIELD_RESET;

      // reset configuration: rotation wraps, then every correction sector on both sides
      plan_req_known(MODE_LOAD, 0, 0, 0, 0, AREA_A);
      plan_req_known(MODE_ROTATE, 16383, 0, 0, 4863, AREA_A);
      plan_req_known(MODE_ROTATE, -16384, 0, 0, 5759, AREA_A);
      plan_req_known(MODE_ROTATE, 1, 0, 0, 0, AREA_A);
      plan_req_known(MODE_ROTATE, 719, 0, 0, 719, AREA_A);
      plan_req_known(MODE_CORRECT, 0, 6400, 0, 0, AREA_B);
      plan_req_known(MODE_ROTATE, 720, 6400, 0, 720, AREA_B);
      plan_req_known(MODE_CORRECT, -16384, 6400, 22784, 1440, AREA_C);
      plan_req_known(MODE_ROTATE, 719, 6400, 22784, 2159, AREA_C);
      plan_req_known(MODE_CORRECT, 16383, 6400, -9983, 1440, AREA_B);
      plan_req_known(MODE_ROTATE, 720, 6400, -9983, 2160, AREA_B);
      plan_req_known(MODE_CORRECT, -16384, -16384, -9983, 2880, AREA_A);
      plan_req_known(MODE_ROTATE, 719, -16384, -9983, 3599, AREA_A);
      plan_req_known(MODE_CORRECT, 5, 5, -9983, 2880, AREA_A);
      plan_req_known(MODE_ROTATE, 720, 5, -9983, 3600, AREA_A);
      plan_req_known(MODE_CORRECT, 100, 5, 100, 4320, AREA_A);
      plan_req_known(MODE_ROTATE, 719, 5, 100, 5039, AREA_A);
      plan_req_known(MODE_CORRECT, 6000, 5, 6000, 4320, AREA_D);
      plan_req_known(MODE_ROTATE, 720, 5, 6000, 5040, AREA_D);
      plan_req_known(MODE_CORRECT, 6400, 0, 6000, 0, AREA_D);
      plan_req_known(MODE_ROTATE, -1, 0, 6000, 5759, AREA_D);
      plan_req_known(MODE_CORRECT, 7000, -600, 6000, 0, AREA_D);
      plan_req(MODE_STRAIGHT, 16383);
      plan_req(MODE_ROTATE, 2000);
      plan_req(MODE_STRAIGHT, -16384);
      // extreme start pose, out-of-range start heading, junk in the upper bits
      plan_csr(REG_START_X, 32'hFFFD_FFFF);
      plan_csr(REG_START_Y, 32'h0002_0000);
      plan_csr(REG_START_HEADING, 32'hFFFF_1770);
      plan_csr(REG_FIELD_X_SIZE, 32'h0001_FFFF);
      plan_csr(REG_FIELD_Y_SIZE, 32'd0);
      plan_csr(3'd5, 32'h0000_1234);
      plan_req_known(MODE_LOAD, 0, 131071, -131072, 240, AREA_B);
      plan_req(MODE_STRAIGHT, 16383);
      plan_req(MODE_CORRECT, -16384);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            csr_write(plan[i].csr_idx, plan[i].csr_data);
         end else begin
            issue_request(plan[i].mode, plan[i].amount, plan[i].typed, plan[i].want);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         settle();
         program_phase(ph);
         gaps_on = (ph != 2 && ph != PHASES - 1);
         for (n = 0; n < PHASE_LEN; n++) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) mode = MODE_LOAD;
            else if (pick < 7) mode = MODE_STRAIGHT;
            else if (pick < 12) mode = MODE_ROTATE;
            else mode = MODE_CORRECT;
            pick = $urandom_range(0, 19);
            if (pick < 12) amount = AMT_W'($urandom());
            else if (pick < 17) amount = AMT_W'(int'($urandom_range(0, 400)) - 200);
            else begin
               case ($urandom_range(0, 3))
                  0: amount = -16384;
                  1: amount = 16383;
                  2: amount = 0;
                  default: amount = -1;
               endcase
            end
            issue_request(mode, amount, 1'b0, '0);
         end
      end

      settle();
      repeat (5) @(posedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

### dead_reckoning_pose_tracker_unit.f
+incdir+rtl
rtl/drpt_pkg.sv
rtl/drpt_csr.sv
rtl/drpt_sine_rom.sv
rtl/drpt_pose_step.sv
rtl/dead_reckoning_pose_tracker_unit.sv
tb/dead_reckoning_pose_tracker_unit_test.sv
